/* hw/rtl/fbpa_pkg.sv */
`timescale 1ns / 1ps

package fbpa_pkg;

   // Default build values
   localparam int DEF_FAST_SLOTS   = 4;
   localparam int DEF_REGION_BYTES = 32768;
   localparam int DEF_HEADER_BYTES = 16;
   localparam int DEF_ALIGN_BYTES  = 8;

   // Fixed field widths
   localparam int ADDR_W  = 15;   // byte offset inside the region
   localparam int RSIZE_W = 16;   // request size
   localparam int ELEM_W  = 11;   // element_size register
   localparam int BLOCK_W = 15;   // block_size register
   localparam int ES_W    = 12;   // effective element size, up to 2048
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Link memory
   localparam int LINK_DEPTH = 4096;
   localparam int LINK_AW    = 12;

   // Register reset values
   localparam logic [ELEM_W-1:0]  ELEM_RESET  = 11'd8;
   localparam logic [BLOCK_W-1:0] BLOCK_RESET = 15'd4080;

   // Register indexes (csr_paddr[2])
   localparam logic REG_ELEMENT_SIZE = 1'b0;
   localparam logic REG_BLOCK_SIZE   = 1'b1;

   // Operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SIZE  = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   // Fast slot bank command and status
   typedef struct packed {
      logic              take;
      logic              put;
      logic [ADDR_W-1:0] put_addr;
   } slot_cmd_type;

   typedef struct packed {
      logic              any_full;
      logic              has_empty;
      logic [ADDR_W-1:0] take_addr;
   } slot_stat_type;

   // Finished result from the controller
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] granted;
      status_type        status;
   } result_type;

endpackage

/* hw/rtl/fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps

// Fixed-size element pool allocator. Each request transfer (get or put) gives
// exactly one response transfer, in order. Items are handled one at a time:
// a put, a bad size, an exhausted get or a get served from a fast slot goes
// from the decide state straight to done; a get from the free list passes
// the pop state, as the link of the list head comes from the registered link
// memory; a get that carves a new block passes the carve state, which hands
// the rest of the block back to the pool, one element per cycle. The finished
// result sits in an output register, so the next request is accepted as soon
// as the result is loaded. Configure element_size (offset 0x0) and block_size
// (offset 0x4) only while no request is in flight. The link memory has no
// reset; it is read only after an entry has been written.
module fixed_block_pool_allocator #(
   parameter int FAST_SLOTS   = fbpa_pkg::DEF_FAST_SLOTS,
   parameter int REGION_BYTES = fbpa_pkg::DEF_REGION_BYTES,
   parameter int HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES,
   parameter int ALIGN_BYTES  = fbpa_pkg::DEF_ALIGN_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // address[14:0], request_size[30:15]
   input  logic [0:0]                  req_tuser,   // operation[0]
   // Response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // granted_address[14:0]
   output logic [1:0]                  rsp_tuser,   // status[1:0]
   // Configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [fbpa_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [fbpa_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [fbpa_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   import fbpa_pkg::*;

   logic [ES_W-1:0]    eff_size;
   logic [BLOCK_W-1:0] block_size;
   result_type         result;
   logic               out_ready;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff,  rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;

   fbpa_cfg #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_size    (eff_size),
      .block_size  (block_size)
   );

   fbpa_ctrl #(
      .FAST_SLOTS   (FAST_SLOTS),
      .REGION_BYTES (REGION_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser[0]),
      .req_addr   (req_tdata[ADDR_W-1:0]),
      .req_size   (req_tdata[ADDR_W +: RSIZE_W]),
      .eff_size   (eff_size),
      .block_size (block_size),
      .out_ready  (out_ready),
      .result     (result)
   );

   // Output register: loads a finished result when empty or being drained
   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (out_ready) begin
         rsp_valid_in  = result.valid;
         rsp_addr_in   = result.granted;
         rsp_status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* hw/rtl/fbpa_ram.sv */
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/fbpa_cfg.sv */
`timescale 1ns / 1ps

module fbpa_cfg #(
   parameter int ALIGN_BYTES = fbpa_pkg::DEF_ALIGN_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fbpa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fbpa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fbpa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [fbpa_pkg::ES_W-1:0]     eff_size,
   output logic [fbpa_pkg::BLOCK_W-1:0]  block_size
);

   import fbpa_pkg::*;

   logic [ELEM_W-1:0]  elem_ff,  elem_in;
   logic [BLOCK_W-1:0] block_ff, block_in;
   logic               wr_en;
   logic [ES_W-1:0]    elem_up;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode
   always_comb begin
      elem_in  = elem_ff;
      block_in = block_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_ELEMENT_SIZE: elem_in  = csr_pwdata[ELEM_W-1:0];
            REG_BLOCK_SIZE:   block_in = csr_pwdata[BLOCK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff  <= ELEM_RESET;
         block_ff <= BLOCK_RESET;
      end else begin
         elem_ff  <= elem_in;
         block_ff <= block_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (csr_paddr[2])
         REG_ELEMENT_SIZE: csr_prdata = CSR_DW'(elem_ff);
         REG_BLOCK_SIZE:   csr_prdata = CSR_DW'(block_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Element size rounded up to the alignment; zero counts as one alignment unit
   assign elem_up  = (ES_W'(elem_ff) + ES_W'(ALIGN_BYTES - 1)) & ~ES_W'(ALIGN_BYTES - 1);
   assign eff_size = (elem_up == '0) ? ES_W'(ALIGN_BYTES) : elem_up;

   assign block_size = block_ff;

endmodule

/* hw/rtl/fbpa_slots.sv */
`timescale 1ns / 1ps

module fbpa_slots #(
   parameter int FAST_SLOTS = fbpa_pkg::DEF_FAST_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fbpa_pkg::slot_cmd_type  cmd,
   output fbpa_pkg::slot_stat_type stat
);

   import fbpa_pkg::*;

   logic [ADDR_W-1:0]     slot_ff [FAST_SLOTS];
   logic [ADDR_W-1:0]     slot_in [FAST_SLOTS];
   logic [FAST_SLOTS-1:0] take_sel;
   logic [FAST_SLOTS-1:0] put_sel;
   logic                  seen_full;
   logic                  seen_empty;
   logic [ADDR_W-1:0]     take_addr;

   // First occupied and first empty slot, lowest index wins
   always_comb begin
      seen_full  = 1'b0;
      seen_empty = 1'b0;
      take_addr  = '0;
      take_sel   = '0;
      put_sel    = '0;
      for (int i = 0; i < FAST_SLOTS; i++) begin
         if (slot_ff[i] != '0 && !seen_full) begin
            take_sel[i] = 1'b1;
            take_addr   = slot_ff[i];
            seen_full   = 1'b1;
         end
         if (slot_ff[i] == '0 && !seen_empty) begin
            put_sel[i] = 1'b1;
            seen_empty = 1'b1;
         end
      end
   end

   assign stat.any_full  = seen_full;
   assign stat.has_empty = seen_empty;
   assign stat.take_addr = take_addr;

   // Slot update: take clears, put fills
   always_comb begin
      for (int i = 0; i < FAST_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
         if (cmd.take && take_sel[i]) begin
            slot_in[i] = '0;
         end else if (cmd.put && put_sel[i]) begin
            slot_in[i] = cmd.put_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FAST_SLOTS; i++) begin
         if (reset) begin
            slot_ff[i] <= '0;
         end else begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

endmodule

/* hw/rtl/fbpa_ctrl.sv */
`timescale 1ns / 1ps

module fbpa_ctrl #(
   parameter int FAST_SLOTS   = fbpa_pkg::DEF_FAST_SLOTS,
   parameter int REGION_BYTES = fbpa_pkg::DEF_REGION_BYTES,
   parameter int HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES,
   parameter int ALIGN_BYTES  = fbpa_pkg::DEF_ALIGN_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [fbpa_pkg::ADDR_W-1:0]   req_addr,
   input  logic [fbpa_pkg::RSIZE_W-1:0]  req_size,
   input  logic [fbpa_pkg::ES_W-1:0]     eff_size,
   input  logic [fbpa_pkg::BLOCK_W-1:0]  block_size,
   input  logic                          out_ready,
   output fbpa_pkg::result_type          result
);

   import fbpa_pkg::*;

   localparam int NW = $clog2(REGION_BYTES + 1);       // bump pointer width
   localparam int SW = ((NW > BLOCK_W) ? NW : BLOCK_W) + 1;
   localparam int AS = $clog2(ALIGN_BYTES);
   localparam int RW = RSIZE_W + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_POP    = 5'b00100,
      S_CARVE  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type          state_ff,  state_in;
   logic               op_ff,     op_in;
   logic [ADDR_W-1:0]  addr_ff,   addr_in;
   logic [RSIZE_W-1:0] rsize_ff,  rsize_in;
   logic [ADDR_W-1:0]  head_ff,   head_in;
   logic [NW-1:0]      bump_ff,   bump_in;
   logic [ADDR_W-1:0]  pos_ff,    pos_in;
   logic [BLOCK_W-1:0] left_ff,   left_in;
   logic [ADDR_W-1:0]  grant_ff,  grant_in;
   status_type         status_ff, status_in;

   slot_cmd_type       slot_cmd;
   slot_stat_type      slot_stat;

   logic               link_we;
   logic [LINK_AW-1:0] link_waddr;
   logic [LINK_AW-1:0] link_raddr;
   logic [ADDR_W-1:0]  link_rdata;

   logic               rel_en;
   logic [ADDR_W-1:0]  rel_addr;
   logic [ADDR_W-1:0]  rel_shift;
   logic [ADDR_W-1:0]  head_shift;
   logic [RW-1:0]      size_up;
   logic               bad_size;
   logic               too_short;
   logic               too_far;
   logic [ADDR_W-1:0]  first_elem;

   fbpa_slots #(
      .FAST_SLOTS (FAST_SLOTS)
   ) u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .stat  (slot_stat)
   );

   fbpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (head_ff),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Link memory index: offset in alignment units
   assign rel_shift  = rel_addr >> AS;
   assign head_shift = head_ff >> AS;
   assign link_waddr = rel_shift[LINK_AW-1:0];
   assign link_raddr = head_shift[LINK_AW-1:0];

   // Size check
   assign size_up  = (RW'(rsize_ff) + RW'(ALIGN_BYTES - 1)) & ~RW'(ALIGN_BYTES - 1);
   assign bad_size = (rsize_ff != '0) && (size_up != RW'(eff_size));

   // Carve feasibility
   assign too_short  = (RW'(block_size) < RW'(HEADER_BYTES) + RW'(eff_size));
   assign too_far    = (SW'(bump_ff) + SW'(block_size)) > SW'(REGION_BYTES);
   assign first_elem = ADDR_W'(bump_ff) + ADDR_W'(HEADER_BYTES);

   assign req_ready = (state_ff == S_IDLE);

   assign result.valid   = (state_ff == S_DONE);
   assign result.granted = grant_ff;
   assign result.status  = status_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      rsize_in  = rsize_ff;
      head_in   = head_ff;
      bump_in   = bump_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      grant_in  = grant_ff;
      status_in = status_ff;
      slot_cmd  = '0;
      link_we   = 1'b0;
      rel_en    = 1'b0;
      rel_addr  = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               addr_in  = req_addr;
               rsize_in = req_size;
               state_in = S_DECIDE;
            end
         end

         // Pick the service path; the link read for a pop is issued here
         S_DECIDE: begin
            grant_in  = '0;
            status_in = ST_OK;
            state_in  = S_DONE;
            if (bad_size) begin
               status_in = ST_BAD_SIZE;
            end else if (op_ff == OP_PUT) begin
               rel_en = 1'b1;
            end else if (slot_stat.any_full) begin
               slot_cmd.take = 1'b1;
               grant_in      = slot_stat.take_addr;
            end else if (head_ff != '0) begin
               state_in = S_POP;
            end else if (too_short || too_far) begin
               status_in = ST_EXHAUSTED;
            end else begin
               bump_in  = NW'(SW'(bump_ff) + SW'(block_size));
               grant_in = first_elem;
               pos_in   = first_elem + ADDR_W'(eff_size);
               left_in  = block_size - BLOCK_W'(HEADER_BYTES) - BLOCK_W'(eff_size);
               state_in = S_CARVE;
            end
         end

         // Link data of the old head is back
         S_POP: begin
            grant_in = head_ff;
            head_in  = link_rdata;
            state_in = S_DONE;
         end

         // One element of the new block released per cycle
         S_CARVE: begin
            if (left_ff > BLOCK_W'(eff_size)) begin
               rel_en   = 1'b1;
               rel_addr = pos_ff;
               pos_in   = pos_ff + ADDR_W'(eff_size);
               left_in  = left_ff - BLOCK_W'(eff_size);
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Release: first empty fast slot, else push on the free list
      if (rel_en && rel_addr != '0) begin
         if (slot_stat.has_empty) begin
            slot_cmd.put      = 1'b1;
            slot_cmd.put_addr = rel_addr;
         end else begin
            link_we = 1'b1;
            head_in = rel_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         bump_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         bump_ff  <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      rsize_ff  <= rsize_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      grant_ff  <= grant_in;
      status_ff <= status_in;
   end

endmodule

/* test/fixed_block_pool_allocator_tb.sv */
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int FAST        = DEF_FAST_SLOTS;
   localparam int REGION      = DEF_REGION_BYTES;
   localparam int HDR         = DEF_HEADER_BYTES;
   localparam int ALIGN       = DEF_ALIGN_BYTES;
   localparam int STALL_LIMIT = 20000;
   localparam int END_CYCLES  = 20;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] addr;
      logic [RSIZE_W-1:0] rsize;
   } alloc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted;
      status_type        status;
   } alloc_rsp_type;

   // Clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [31:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;

   logic req_tready;
   logic rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   fixed_block_pool_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // address[14:0], request_size[30:15]
      .req_tuser   (req_tuser),    // operation[0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // granted_address[14:0]
      .rsp_tuser   (rsp_tuser),    // status[1:0]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Stimulus and scoreboard storage
   alloc_req_type     req_backlog[$];
   alloc_rsp_type     grants_due[$];
   logic [ADDR_W-1:0] held_addrs[$];   // granted and not yet handed back
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                fail_count = 0;
   int                quiet_cycles = 0;
   bit                req_went = 1'b0;

   // Shadow allocator state
   int unsigned       elem_size_reg = 8;
   int unsigned       block_size_reg = 4080;
   logic [ADDR_W-1:0] slot_addr [FAST];
   logic [ADDR_W-1:0] free_top;
   logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
   int unsigned       carve_offset;

   initial begin
      for (int i = 0; i < FAST; i++) slot_addr[i] = '0;
      free_top = '0;
      carve_offset = 0;
   end

   function automatic int unsigned align_up(int unsigned v);
      return (v + ALIGN - 1) & ~(ALIGN - 1);
   endfunction

   function automatic int unsigned unit_bytes();
      int unsigned s;
      s = align_up(elem_size_reg);
      return (s == 0) ? ALIGN : s;
   endfunction

   // Hand an element back: first empty fast slot, else push on the free list
   function automatic void recycle(logic [ADDR_W-1:0] a);
      if (a == '0) return;
      for (int i = 0; i < FAST; i++) begin
         if (slot_addr[i] == '0) begin
            slot_addr[i] = a;
            return;
         end
      end
      link_mem[(a / ALIGN) % LINK_DEPTH] = free_top;
      free_top = a;
   endfunction

   // Expected response of one request; updates the shadow state
   function automatic alloc_rsp_type predict_grant(alloc_req_type r);
      alloc_rsp_type res;
      int unsigned   es, rs, pos, left, base;
      bit            found;
      es = unit_bytes();
      rs = 32'(r.rsize);
      res.granted = '0;
      res.status = ST_OK;
      found = 1'b0;
      if (rs != 0 && rs != es && align_up(rs) != es) begin
         res.status = ST_BAD_SIZE;
      end else if (r.op == OP_PUT) begin
         recycle(r.addr);
      end else begin
         for (int i = 0; i < FAST; i++) begin
            if (!found && slot_addr[i] != '0) begin
               res.granted = slot_addr[i];
               slot_addr[i] = '0;
               found = 1'b1;
            end
         end
         if (!found && free_top != '0) begin
            res.granted = free_top;
            free_top = link_mem[(free_top / ALIGN) % LINK_DEPTH];
            found = 1'b1;
         end
         if (!found) begin
            base = carve_offset;
            if (block_size_reg < HDR + es || base + block_size_reg > REGION) begin
               res.status = ST_EXHAUSTED;
            end else begin
               // grant the first element, return the rest to the pool
               pos = base + HDR;
               left = block_size_reg - HDR;
               carve_offset = base + block_size_reg;
               res.granted = pos[ADDR_W-1:0];
               pos += es;
               left -= es;
               while (left > es) begin
                  recycle(pos[ADDR_W-1:0]);
                  pos += es;
                  left -= es;
               end
            end
         end
      end
      return res;
   endfunction

   // Request driver
   alloc_req_type nxt_req;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_went) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt_req = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, nxt_req.rsize, nxt_req.addr};
            req_tuser <= nxt_req.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: check responses, predict on each accepted request
   alloc_req_type seen_req;
   alloc_rsp_type due, pred;
   always @(posedge clock) begin
      req_went = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            $error("unexpected response transfer: granted_address %0d status %0d",
                   rsp_tdata[ADDR_W-1:0], rsp_tuser);
            fail_count++;
         end else begin
            due = grants_due.pop_front();
            if (rsp_tdata[ADDR_W-1:0] !== due.granted) begin
               $error("granted_address: expected %0d, got %0d",
                      due.granted, rsp_tdata[ADDR_W-1:0]);
               fail_count++;
            end
            if (rsp_tuser !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_tuser);
               fail_count++;
            end
         end
      end
      if (req_went) begin
         seen_req.op = req_tuser[0];
         seen_req.addr = req_tdata[ADDR_W-1:0];
         seen_req.rsize = req_tdata[ADDR_W+RSIZE_W-1:ADDR_W];
         pred = predict_grant(seen_req);
         grants_due.push_back(pred);
         if (seen_req.op == OP_GET && pred.status == ST_OK) held_addrs.push_back(pred.granted);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("fixed_block_pool_allocator test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic idx, input int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_ELEMENT_SIZE) elem_size_reg = value & 32'h7ff;
      else block_size_reg = value & 32'h7fff;
   endtask

   task automatic queue_item(input logic op, input int unsigned addr, input int unsigned rsize);
      alloc_req_type r;
      r.op = op;
      r.addr = addr[ADDR_W-1:0];
      r.rsize = rsize[RSIZE_W-1:0];
      req_backlog.push_back(r);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || grants_due.size() != 0);
   endtask

   // Random traffic: mostly legal get/put with handed-out addresses, some noise
   task automatic run_random(input int count);
      alloc_req_type r;
      int unsigned   es, get_pct, k;
      es = unit_bytes();
      get_pct = 55;
      for (int n = 0; n < count; n++) begin
         // switch at random between get-heavy, balanced and put-heavy stretches to drain and refill the pool
         if (n % 50 == 0) get_pct = 30 + 27 * $urandom_range(0, 2);
         while (req_backlog.size() > 1) @(posedge clock);
         r.addr = ADDR_W'($urandom_range(0, 32767));
         if ($urandom_range(0, 99) < 8) begin
            r.op = 1'($urandom_range(0, 1));
            r.rsize = RSIZE_W'($urandom_range(0, 65535));
         end else begin
            case ($urandom_range(0, 2))
               0: r.rsize = '0;
               1: r.rsize = RSIZE_W'(es);
               default: r.rsize = RSIZE_W'(es - $urandom_range(0, ALIGN - 1));
            endcase
            if ($urandom_range(0, 99) < get_pct) begin
               r.op = OP_GET;
            end else begin
               r.op = OP_PUT;
               if (held_addrs.size() != 0 && $urandom_range(0, 99) < 95) begin
                  k = $urandom_range(0, held_addrs.size() - 1);
                  r.addr = held_addrs[k];
                  held_addrs.delete(k);
               end
            end
         end
         req_backlog.push_back(r);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 45;

      // block too small for header plus one element: every carve is refused
      write_reg(REG_ELEMENT_SIZE, 2040);
      write_reg(REG_BLOCK_SIZE, 2048);
      queue_item(OP_GET, 0, 0);
      queue_item(OP_GET, 32767, 2033);
      queue_item(OP_PUT, 0, 0);           // zero address is ignored
      queue_item(OP_PUT, 100, 65535);     // bad size
      wait_drained();

      // element size 0 behaves as 8; fast slots then free list, no carving
      write_reg(REG_ELEMENT_SIZE, 0);
      write_reg(REG_BLOCK_SIZE, 4080);
      queue_item(OP_PUT, 32767, 0);
      queue_item(OP_GET, 0, 8);
      queue_item(OP_GET, 0, 9);           // rounds to 16, bad size
      queue_item(OP_PUT, 16, 1);
      queue_item(OP_PUT, 24, 8);
      queue_item(OP_PUT, 8, 0);
      queue_item(OP_PUT, 5, 0);           // foreign unaligned address, slots now full
      queue_item(OP_PUT, 32760, 3);       // onto the free list
      queue_item(OP_PUT, 9, 0);           // shares a link entry with 8
      queue_item(OP_GET, 0, 0);
      queue_item(OP_GET, 0, 0);
      queue_item(OP_GET, 0, 0);
      queue_item(OP_GET, 0, 0);
      queue_item(OP_GET, 0, 0);           // pops free list head
      queue_item(OP_PUT, 0, 8);
      queue_item(OP_GET, 0, 0);
      wait_drained();

      // remainder equals one element: carve hands nothing back
      write_reg(REG_ELEMENT_SIZE, 2032);
      queue_item(OP_GET, 0, 2025);
      wait_drained();

      // few large elements per block: frequent carving, then exhaustion
      write_reg(REG_ELEMENT_SIZE, 2040);
      write_reg(REG_BLOCK_SIZE, 12000);
      run_random(380);
      wait_drained();

      send_idle_pct = 45;
      recv_idle_pct = 23;
      write_reg(REG_ELEMENT_SIZE, 13);
      write_reg(REG_BLOCK_SIZE, 4080);
      run_random(380);
      wait_drained();

      // largest block never fits any more: reuse only
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_ELEMENT_SIZE, 1000);
      write_reg(REG_BLOCK_SIZE, 32752);
      run_random(380);
      wait_drained();

      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("fixed_block_pool_allocator test passed");
      end else begin
         $display("fixed_block_pool_allocator test failed");
      end
      $finish;
   end

endmodule
